@@ src/owm_pkg.sv @@
// Shared types, codes and reset values for the one-wire bus master.
package owm_pkg;

    localparam int TICK_W   = 10;
    localparam int PULSE_W  = 6;
    localparam int BIT_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Command codes carried in the func field
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE   = 3'd5;

    localparam logic [TICK_W-1:0]  RST_RESET_LOW     = 10'd550;
    localparam logic [TICK_W-1:0]  RST_PRESENCE_WAIT = 10'd40;
    localparam logic [TICK_W-1:0]  RST_PRESENCE_HOLD = 10'd240;
    localparam logic [TICK_W-1:0]  RST_WRITE_SLOT    = 10'd40;
    localparam logic [TICK_W-1:0]  RST_READ_SLOT     = 10'd70;
    localparam logic [PULSE_W-1:0] RST_SHORT_PULSE   = 6'd1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_PRES = 3'd3,
        PH_RST_HOLD = 3'd4,
        PH_WRITE    = 3'd5,
        PH_READ     = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_byte;
        logic       line_level;
    } t_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_out;

    typedef struct packed {
        logic [TICK_W-1:0]  reset_low_ticks;
        logic [TICK_W-1:0]  presence_wait_ticks;
        logic [TICK_W-1:0]  presence_hold_ticks;
        logic [TICK_W-1:0]  write_slot_ticks;
        logic [TICK_W-1:0]  read_slot_ticks;
        logic [PULSE_W-1:0] short_pulse_ticks;
    } t_cfg;

    // A programmed length of zero behaves as one tick
    function automatic logic [TICK_W-1:0] len_of(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

@@ src/owm_seq.sv @@
// Bus sequencer: phase, slot timer and shift register, one tick per step.
module owm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  owm_pkg::t_in   i_item,
    input  owm_pkg::t_cfg  i_cfg,
    output owm_pkg::t_out  o_res
);

    owm_pkg::t_phase r_phase, n_phase;
    logic [owm_pkg::BIT_W-1:0]  r_bit, n_bit;
    logic [owm_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [7:0]                 r_shift, n_shift;
    logic [7:0]                 r_last, n_last;

    owm_pkg::t_phase            ph;
    logic [owm_pkg::BIT_W-1:0]  bit_c;
    logic [owm_pkg::TICK_W-1:0] tick_c;
    logic [7:0]                 shift_c;
    logic [owm_pkg::TICK_W-1:0] tick_inc;
    logic [owm_pkg::TICK_W-1:0] cur_len;
    logic                       len_end;
    logic [owm_pkg::TICK_W-1:0] pulse_ext;
    logic [owm_pkg::TICK_W-1:0] rd_len;
    logic [owm_pkg::TICK_W-1:0] sample_at;
    logic                       pulse_on;

    // Command start on an idle tick: this same tick is the first of the sequence
    always_comb begin
        ph      = r_phase;
        bit_c   = r_bit;
        tick_c  = r_tick;
        shift_c = r_shift;
        if (r_phase == owm_pkg::PH_IDLE && i_item.func != owm_pkg::FUNC_TICK) begin
            tick_c = '0;
            bit_c  = '0;
            case (i_item.func)
                owm_pkg::FUNC_RESET: ph = owm_pkg::PH_RST_LOW;
                owm_pkg::FUNC_WRITE: begin
                    ph      = owm_pkg::PH_WRITE;
                    shift_c = i_item.write_byte;
                end
                default: begin
                    ph      = owm_pkg::PH_READ;
                    shift_c = '0;
                end
            endcase
        end
    end

    always_comb begin
        case (ph)
            owm_pkg::PH_RST_LOW:  cur_len = owm_pkg::len_of(i_cfg.reset_low_ticks);
            owm_pkg::PH_RST_WAIT: cur_len = owm_pkg::len_of(i_cfg.presence_wait_ticks);
            owm_pkg::PH_RST_HOLD: cur_len = owm_pkg::len_of(i_cfg.presence_hold_ticks);
            owm_pkg::PH_WRITE:    cur_len = owm_pkg::len_of(i_cfg.write_slot_ticks);
            default:              cur_len = owm_pkg::len_of(i_cfg.read_slot_ticks);
        endcase
    end

    assign tick_inc  = tick_c + owm_pkg::TICK_W'(1);
    assign len_end   = (tick_inc >= cur_len);
    assign pulse_ext = owm_pkg::TICK_W'(i_cfg.short_pulse_ticks);
    assign pulse_on  = (tick_c < pulse_ext);
    assign rd_len    = owm_pkg::len_of(i_cfg.read_slot_ticks);
    assign sample_at = (pulse_ext >= rd_len) ? rd_len - owm_pkg::TICK_W'(1) : pulse_ext;

    always_comb begin
        n_phase = ph;
        n_bit   = bit_c;
        n_tick  = tick_c;
        n_shift = shift_c;
        n_last  = r_last;
        case (ph)
            owm_pkg::PH_RST_LOW: begin
                n_tick = len_end ? '0 : tick_inc;
                if (len_end) begin
                    n_phase = owm_pkg::PH_RST_WAIT;
                end
            end
            owm_pkg::PH_RST_WAIT: begin
                n_tick = len_end ? '0 : tick_inc;
                if (len_end) begin
                    n_phase = owm_pkg::PH_RST_PRES;
                end
            end
            owm_pkg::PH_RST_PRES: begin
                if (!i_item.line_level) begin
                    n_phase = owm_pkg::PH_RST_HOLD;
                    n_tick  = '0;
                end
            end
            owm_pkg::PH_RST_HOLD: begin
                n_tick = len_end ? '0 : tick_inc;
                if (len_end) begin
                    n_phase = owm_pkg::PH_IDLE;
                end
            end
            owm_pkg::PH_WRITE: begin
                n_tick = len_end ? '0 : tick_inc;
                if (len_end) begin
                    n_shift = {1'b0, shift_c[7:1]};
                    if (bit_c == '1) begin
                        n_phase = owm_pkg::PH_IDLE;
                        n_bit   = '0;
                    end else begin
                        n_bit = bit_c + owm_pkg::BIT_W'(1);
                    end
                end
            end
            owm_pkg::PH_READ: begin
                // Sample only once the pulse is released; a still-driven line reads 0
                if (tick_c == sample_at) begin
                    n_shift = {i_item.line_level & ~pulse_on, shift_c[7:1]};
                end
                n_tick = len_end ? '0 : tick_inc;
                if (len_end) begin
                    if (bit_c == '1) begin
                        n_phase = owm_pkg::PH_IDLE;
                        n_bit   = '0;
                        n_last  = n_shift;
                    end else begin
                        n_bit = bit_c + owm_pkg::BIT_W'(1);
                    end
                end
            end
            default: n_phase = owm_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        o_res.busy_res = (ph != owm_pkg::PH_IDLE);
        o_res.done_res = (ph != owm_pkg::PH_IDLE) && (n_phase == owm_pkg::PH_IDLE);
        case (ph)
            owm_pkg::PH_RST_LOW: o_res.drive_low = 1'b1;
            owm_pkg::PH_WRITE:   o_res.drive_low = ~shift_c[0] | pulse_on;
            owm_pkg::PH_READ:    o_res.drive_low = pulse_on;
            default:             o_res.drive_low = 1'b0;
        endcase
        o_res.read_byte = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owm_pkg::PH_IDLE;
            r_bit   <= '0;
            r_tick  <= '0;
            r_shift <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_last  <= n_last;
        end
    end

endmodule

@@ src/one_wire_bus_master.sv @@
// Throughput: one tick per cycle while o_stall is low; the sequencer state is
// updated at accept. Each result is registered in the output register, or in
// the one skid entry while that register is held.
// o_stall rises only while both output entries are full.
// Reset (i_rst_n low, synchronous): bus idle, output empty, registers at their
// defaults (550, 40, 240, 40, 70, 1), last read byte 0.
module one_wire_bus_master (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  owm_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output owm_pkg::t_out                 o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owm_pkg::TICK_W-1:0]    i_cfg_data
);

    owm_pkg::t_cfg r_cfg;
    owm_pkg::t_out res;
    owm_pkg::t_out r_out, r_skid;
    logic          r_out_valid, r_skid_valid;
    logic          in_acc, out_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= owm_pkg::RST_RESET_LOW;
            r_cfg.presence_wait_ticks <= owm_pkg::RST_PRESENCE_WAIT;
            r_cfg.presence_hold_ticks <= owm_pkg::RST_PRESENCE_HOLD;
            r_cfg.write_slot_ticks    <= owm_pkg::RST_WRITE_SLOT;
            r_cfg.read_slot_ticks     <= owm_pkg::RST_READ_SLOT;
            r_cfg.short_pulse_ticks   <= owm_pkg::RST_SHORT_PULSE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owm_pkg::CFG_RESET_LOW:     r_cfg.reset_low_ticks     <= i_cfg_data;
                owm_pkg::CFG_PRESENCE_WAIT: r_cfg.presence_wait_ticks <= i_cfg_data;
                owm_pkg::CFG_PRESENCE_HOLD: r_cfg.presence_hold_ticks <= i_cfg_data;
                owm_pkg::CFG_WRITE_SLOT:    r_cfg.write_slot_ticks    <= i_cfg_data;
                owm_pkg::CFG_READ_SLOT:     r_cfg.read_slot_ticks     <= i_cfg_data;
                owm_pkg::CFG_SHORT_PULSE:
                    r_cfg.short_pulse_ticks <= i_cfg_data[owm_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall = r_skid_valid;
    assign in_acc  = i_valid & ~r_skid_valid;
    assign out_pop = r_out_valid & ~i_stall;

    owm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc),
        .i_item  (i_data),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Head register feeds the port; skid holds one transaction while the head is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_acc && !r_out_valid) begin
            r_out <= res;
        end
        if (in_acc && r_out_valid && !out_pop) begin
            r_skid <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ src/owm_checker.sv @@
// Port-level checks for the one-wire bus master, bound to the top level.
module owm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input owm_pkg::t_in                  i_data,
    input logic                          o_valid,
    input logic                          i_stall,
    input owm_pkg::t_out                 o_data,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [owm_pkg::TICK_W-1:0]    i_cfg_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled transaction changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with output empty");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.done_res) |-> o_data.busy_res)
        else $error("done outside a sequence");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.drive_low) |-> o_data.busy_res)
        else $error("line driven while idle");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);
